// ===== rtl/tgc_pkg.sv =====
package tgc_pkg;

	localparam int CoordW   = 12;
	localparam int ThreshW  = 12;
	localparam int TimeW    = 48;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 48;
	localparam int InDataW  = 96;
	localparam int OutDataW = 8;

	localparam logic [ThreshW-1:0] TapThreshRst   = 12'd15;
	localparam logic [ThreshW-1:0] SwipeThreshRst = 12'd30;
	localparam logic [TimeW-1:0]   KeepaliveRst   = 48'd3000000;

	// coordinate high byte: only the low nibble carries position bits
	localparam logic [7:0] CoordHiMask = 8'h0F;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TAP       = 2'd0,
		CFG_SWIPE     = 2'd1,
		CFG_KEEPALIVE = 2'd2
	} cfg_idx_t;

	// controller gesture byte
	typedef enum logic [7:0] {
		HW_UP    = 8'd1,
		HW_DOWN  = 8'd2,
		HW_LEFT  = 8'd3,
		HW_RIGHT = 8'd4,
		HW_TAP   = 8'd5
	} hw_code_t;

	typedef enum logic [2:0] {
		GEST_NONE  = 3'd0,
		GEST_TAP   = 3'd1,
		GEST_UP    = 3'd2,
		GEST_DOWN  = 3'd3,
		GEST_LEFT  = 3'd4,
		GEST_RIGHT = 3'd5
	} gesture_t;

	typedef struct packed {
		logic [ThreshW-1:0] tap_threshold;
		logic [ThreshW-1:0] swipe_threshold;
		logic [TimeW-1:0]   keepalive_interval_us;
	} cfg_t;

endpackage

// ===== rtl/tgc_cfg.sv =====
module tgc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tgc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tgc_pkg::CfgDataW-1:0] cfg_data,
	output tgc_pkg::cfg_t                cfg
);
	import tgc_pkg::*;

	cfg_t cfg_q;

	// unlisted indexes fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_threshold         <= TapThreshRst;
			cfg_q.swipe_threshold       <= SwipeThreshRst;
			cfg_q.keepalive_interval_us <= KeepaliveRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP:       cfg_q.tap_threshold         <= cfg_data[ThreshW-1:0];
				CFG_SWIPE:     cfg_q.swipe_threshold       <= cfg_data[ThreshW-1:0];
				CFG_KEEPALIVE: cfg_q.keepalive_interval_us <= cfg_data[TimeW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tgc_classify.sv =====
module tgc_classify (
	input  logic [tgc_pkg::CoordW-1:0]  start_x,
	input  logic [tgc_pkg::CoordW-1:0]  start_y,
	input  logic [tgc_pkg::CoordW-1:0]  latest_x,
	input  logic [tgc_pkg::CoordW-1:0]  latest_y,
	input  logic [tgc_pkg::ThreshW-1:0] tap_threshold,
	input  logic [tgc_pkg::ThreshW-1:0] swipe_threshold,
	output tgc_pkg::gesture_t           gesture
);
	import tgc_pkg::*;

	logic              x_pos, y_pos;
	logic [CoordW-1:0] adx, ady;

	assign x_pos = latest_x > start_x;
	assign y_pos = latest_y > start_y;
	assign adx   = x_pos ? latest_x - start_x : start_x - latest_x;
	assign ady   = y_pos ? latest_y - start_y : start_y - latest_y;

	// tap wins; ties between axes fall to none
	always_comb begin
		if (adx < tap_threshold && ady < tap_threshold)
			gesture = GEST_TAP;
		else if (adx > ady && adx >= swipe_threshold)
			gesture = x_pos ? GEST_RIGHT : GEST_LEFT;
		else if (ady > adx && ady >= swipe_threshold)
			gesture = y_pos ? GEST_DOWN : GEST_UP;
		else
			gesture = GEST_NONE;
	end

endmodule

// ===== rtl/touch_gesture_classifier_unit.sv =====
// Touch gesture classifier. Each request on the slave stream is one poll of
// the touch controller and yields exactly one result on the master stream.
// A poll lands in an input register, is evaluated against the tracking state
// combinationally, and its result goes to an output register, so a new poll
// can be taken every cycle while the master side keeps tready high.
// The only stall source is the master side holding tready low.
// The block keeps the touch start and latest position while fingers are
// down; a NACK or an acknowledged poll with no usable finger (zero count or
// x = y = 0) ends the touch and classifies it as tap, swipe or none.
// Controller gesture codes 1..5 pass through and leave tracking untouched.
// Keepalive is flagged on acknowledged polls when (time - last touch time)
// mod 2^48 exceeds the interval. Config writes are meant for idle periods.
module touch_gesture_classifier_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// config write port
	input  logic                         cfg_we,
	input  logic [tgc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tgc_pkg::CfgDataW-1:0] cfg_data,
	// poll requests
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [7:0] hw_gesture, [15:8] finger_count, [23:16] x_high_byte,
	// [31:24] x_low_byte, [39:32] y_high_byte, [47:40] y_low_byte,
	// [95:48] time_us
	input  logic [tgc_pkg::InDataW-1:0]  s_axis_tdata,
	// [0] bus_ack
	input  logic                         s_axis_tuser,
	// results
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [2:0] gesture, [3] keepalive_request, [7:4] zero
	output logic [tgc_pkg::OutDataW-1:0] m_axis_tdata
);
	import tgc_pkg::*;

	cfg_t cfg;

	tgc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---------------- input stage ----------------
	logic              valid_s1;
	logic              ack_s1;
	logic [7:0]        hw_s1;
	logic [7:0]        fingers_s1;
	logic [CoordW-1:0] x_s1, y_s1;
	logic [TimeW-1:0]  time_s1;

	logic out_valid_q;
	logic advance, take_in;

	// s1 moves on when the result register is empty or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ack_s1     <= s_axis_tuser;
			hw_s1      <= s_axis_tdata[7:0];
			fingers_s1 <= s_axis_tdata[15:8];
			x_s1       <= {s_axis_tdata[19:16] & CoordHiMask[3:0], s_axis_tdata[31:24]};
			y_s1       <= {s_axis_tdata[35:32] & CoordHiMask[3:0], s_axis_tdata[47:40]};
			time_s1    <= s_axis_tdata[95:48];
		end
	end

	// ---------------- tracking state ----------------
	logic              touch_active_q;
	logic [CoordW-1:0] start_x_q, start_y_q, latest_x_q, latest_y_q;
	logic [TimeW-1:0]  last_touch_q;

	// ---------------- evaluation ----------------
	logic             hw_hit, coord_ok, track, finish, keep;
	logic [TimeW-1:0] idle_us;
	gesture_t         hw_gest, move_gest, gest;

	tgc_classify u_classify (
		.start_x         (start_x_q),
		.start_y         (start_y_q),
		.latest_x        (latest_x_q),
		.latest_y        (latest_y_q),
		.tap_threshold   (cfg.tap_threshold),
		.swipe_threshold (cfg.swipe_threshold),
		.gesture         (move_gest)
	);

	always_comb begin
		hw_hit = 1'b1;
		case (hw_s1)
			HW_UP:    hw_gest = GEST_UP;
			HW_DOWN:  hw_gest = GEST_DOWN;
			HW_LEFT:  hw_gest = GEST_LEFT;
			HW_RIGHT: hw_gest = GEST_RIGHT;
			HW_TAP:   hw_gest = GEST_TAP;
			default: begin
				hw_gest = GEST_NONE;
				hw_hit  = 1'b0;
			end
		endcase
	end

	// finger reported at a nonzero position
	assign coord_ok = (fingers_s1 != 8'd0) && (x_s1 != '0 || y_s1 != '0);
	assign track    = ack_s1 && !hw_hit && coord_ok;
	assign finish   = touch_active_q && (!ack_s1 || (!hw_hit && !coord_ok));

	// wraps mod 2^48 by width
	assign idle_us = time_s1 - last_touch_q;
	assign keep    = ack_s1 && (idle_us > cfg.keepalive_interval_us);

	always_comb begin
		if (ack_s1 && hw_hit)
			gest = hw_gest;
		else if (finish)
			gest = move_gest;
		else
			gest = GEST_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			start_x_q      <= '0;
			start_y_q      <= '0;
			latest_x_q     <= '0;
			latest_y_q     <= '0;
			last_touch_q   <= '0;
		end else if (advance) begin
			if (track) begin
				last_touch_q   <= time_s1;
				touch_active_q <= 1'b1;
				latest_x_q     <= x_s1;
				latest_y_q     <= y_s1;
				if (!touch_active_q) begin
					start_x_q <= x_s1;
					start_y_q <= y_s1;
				end
			end else if (finish) begin
				touch_active_q <= 1'b0;
			end
		end
	end

	// ---------------- result register ----------------
	gesture_t gest_q;
	logic     keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gest_q <= gest;
			keep_q <= keep;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, keep_q, gest_q};

	// ---------------- checks ----------------
	// a NACK never asks for keepalive
	a_nack_no_keep: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ack_s1 |=> !m_axis_tdata[3])
		else $error("keepalive requested on NACK poll");

	// a touch only ends together with a fresh result
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(touch_active_q) |-> m_axis_tvalid)
		else $error("touch ended without a result");

	// controller gestures leave the tracking state alone
	a_hw_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ack_s1 && hw_hit |=> $stable(touch_active_q) && $stable(start_x_q)
			&& $stable(start_y_q) && $stable(last_touch_q))
		else $error("tracking changed on controller gesture");

endmodule

// ===== bench/tb_touch_gesture_classifier_unit.sv =====
module tb_touch_gesture_classifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	localparam int ItemsPerPhase = 120;
	localparam int HoldOffCycles = 80;
	localparam int StallLimit    = 1000;	// cycles with no handshake on either side

	// one expected result per accepted poll
	typedef struct {
		gesture_t gest;
		logic     keep;
	} poll_result_t;

	// Tracks the touch the same way the block should, and holds the results
	// still owed by the block in acceptance order.
	class touch_tracker;
		logic [ThreshW-1:0] tap_thr;
		logic [ThreshW-1:0] swipe_thr;
		logic [TimeW-1:0]   keep_ivl;
		logic               active;
		logic [CoordW-1:0]  first_x, first_y, last_x, last_y;
		logic [TimeW-1:0]   touch_time;
		poll_result_t       expected_results[$];
		int                 errors;

		function new();
			tap_thr    = TapThreshRst;
			swipe_thr  = SwipeThreshRst;
			keep_ivl   = KeepaliveRst;
			active     = 1'b0;
			first_x    = '0;
			first_y    = '0;
			last_x     = '0;
			last_y     = '0;
			touch_time = '0;
			errors     = 0;
		endfunction

		function void set_config(cfg_idx_t idx, logic [CfgDataW-1:0] v);
			case (idx)
				CFG_TAP:       tap_thr = v[ThreshW-1:0];
				CFG_SWIPE:     swipe_thr = v[ThreshW-1:0];
				CFG_KEEPALIVE: keep_ivl = v[TimeW-1:0];
				default: ;
			endcase
		endfunction

		// touch is over: tap, strictly dominant axis swipe, or nothing
		function gesture_t classify();
			logic [CoordW-1:0] adx, ady;
			active = 1'b0;
			adx = (last_x > first_x) ? last_x - first_x : first_x - last_x;
			ady = (last_y > first_y) ? last_y - first_y : first_y - last_y;
			if (adx < tap_thr && ady < tap_thr)
				return GEST_TAP;
			if (adx > ady && adx >= swipe_thr)
				return (last_x > first_x) ? GEST_RIGHT : GEST_LEFT;
			if (ady > adx && ady >= swipe_thr)
				return (last_y > first_y) ? GEST_DOWN : GEST_UP;
			return GEST_NONE;
		endfunction

		function void take_poll(logic ack, logic [InDataW-1:0] d);
			logic [7:0]        hw;
			logic [7:0]        fingers;
			logic [CoordW-1:0] x, y;
			logic [TimeW-1:0]  now, idle;
			poll_result_t      r;
			hw      = d[7:0];
			fingers = d[15:8];
			x       = {d[19:16], d[31:24]};	// low nibble of the high byte only
			y       = {d[35:32], d[47:40]};
			now     = d[95:48];
			r.gest  = GEST_NONE;
			r.keep  = 1'b0;
			if (!ack) begin
				if (active)
					r.gest = classify();
			end else begin
				idle   = now - touch_time;	// wraps mod 2^48
				r.keep = idle > keep_ivl;
				case (hw)
					HW_UP:    r.gest = GEST_UP;
					HW_DOWN:  r.gest = GEST_DOWN;
					HW_LEFT:  r.gest = GEST_LEFT;
					HW_RIGHT: r.gest = GEST_RIGHT;
					HW_TAP:   r.gest = GEST_TAP;
					default: begin
						if (fingers != 0 && (x != 0 || y != 0)) begin
							touch_time = now;
							if (!active) begin
								active  = 1'b1;
								first_x = x;
								first_y = y;
							end
							last_x = x;
							last_y = y;
						end else if (active) begin
							r.gest = classify();
						end
					end
				endcase
			end
			expected_results.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [OutDataW-1:0] d);
			poll_result_t e;
			if (expected_results.size() == 0) begin
				flag($sformatf("result 0x%02h with no request pending", d));
				return;
			end
			e = expected_results.pop_front();
			if (d[2:0] !== e.gest)
				flag($sformatf("gesture expected %0d, got %0d", e.gest, d[2:0]));
			if (d[3] !== e.keep)
				flag($sformatf("keepalive expected %0b, got %0b", e.keep, d[3]));
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index     = '0;
	logic [CfgDataW-1:0] cfg_data      = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata  = '0;	// hw, fingers, xh, xl, yh, yl, time
	logic                s_axis_tuser  = 1'b0;	// bus_ack
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;	// gesture, keepalive

	touch_tracker     tracker;
	bit               idle_on   = 1'b1;	// random gaps/stalls on both sides
	int               hold_off  = 0;	// one-shot long stall for the result side
	int               polls_sent = 0;
	logic [TimeW-1:0] clock_us  = '0;	// running poll timestamp

	touch_gesture_classifier_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one poll. Entered and left at a falling edge; valid stays high
	// when the next request follows with no gap.
	task automatic send_poll(input logic ack, input logic [7:0] hw, input logic [7:0] fingers,
			input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
			input logic [TimeW-1:0] t);
		int         gap;
		logic [7:0] xh, yh;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		// junk in the unused upper nibble of the high bytes
		xh = {4'($urandom), x[11:8]};
		yh = {4'($urandom), y[11:8]};
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= ack;
		s_axis_tdata  <= {t, y[7:0], yh, x[7:0], xh, fingers, hw};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tracker.take_poll(ack, {t, y[7:0], yh, x[7:0], xh, fingers, hw});
		polls_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until the block has nothing left in flight.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		tracker.set_config(idx, v);
		@(negedge clk);
	endtask

	task automatic program_regs(input logic [ThreshW-1:0] tap, input logic [ThreshW-1:0] swipe,
			input logic [TimeW-1:0] ivl);
		write_reg(CFG_TAP, CfgDataW'(tap));
		write_reg(CFG_SWIPE, CfgDataW'(swipe));
		write_reg(CFG_KEEPALIVE, ivl);
		cfg_we <= 1'b0;
	endtask

	// Mostly small steps; some land right on the keepalive boundary, some
	// jump anywhere (including backwards, which wraps).
	function automatic logic [TimeW-1:0] next_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			clock_us = clock_us + TimeW'($urandom_range(1, 40000));
		else if (r < 90)
			clock_us = tracker.touch_time + tracker.keep_ivl + TimeW'($urandom_range(0, 2)) - 1;
		else
			clock_us = {16'($urandom), 32'($urandom)};
		return clock_us;
	endfunction

	function automatic logic [CoordW-1:0] nudge(logic [CoordW-1:0] c);
		int span;
		int v;
		case ($urandom_range(0, 9))
			0: return CoordW'($urandom);
			1, 2: span = 3;
			default: span = int'(tracker.swipe_thr) + int'(tracker.tap_thr) / 2 + 4;
		endcase
		v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return CoordW'(v);
	endfunction

	// controller code that the block ignores: mostly 0, sometimes above tap
	function automatic logic [7:0] ignored_code();
		return ($urandom_range(0, 4) != 0) ? 8'd0 : 8'($urandom_range(HW_TAP + 1, 255));
	endfunction

	function automatic logic [7:0] some_fingers();
		return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 2)) : 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] pass_code();
		return 8'($urandom_range(HW_UP, HW_TAP));
	endfunction

	// One touch from finger down to release, with the odd controller gesture
	// mixed in; released by NACK, zero fingers, or zero coordinates.
	task automatic touch_stroke();
		logic [CoordW-1:0] x, y;
		int                moves;
		x = CoordW'($urandom);
		y = CoordW'($urandom);
		if (x == 0 && y == 0)
			y = 12'd1;
		moves = $urandom_range(0, 5);
		send_poll(1'b1, ignored_code(), some_fingers(), x, y, next_stamp());
		repeat (moves) begin
			if ($urandom_range(0, 7) == 0) begin
				send_poll(1'b1, pass_code(), 8'($urandom), CoordW'($urandom), CoordW'($urandom),
					next_stamp());
			end else begin
				x = nudge(x);
				y = nudge(y);
				if (x == 0 && y == 0)
					x = 12'd1;
				send_poll(1'b1, ignored_code(), some_fingers(), x, y, next_stamp());
			end
		end
		case ($urandom_range(0, 2))
			0: send_poll(1'b0, 8'($urandom), 8'($urandom), CoordW'($urandom), CoordW'($urandom),
				next_stamp());
			1: send_poll(1'b1, ignored_code(), 8'd0, CoordW'($urandom), CoordW'($urandom),
				next_stamp());
			default: send_poll(1'b1, ignored_code(), some_fingers(), 12'd0, 12'd0, next_stamp());
		endcase
	endtask

	// Result side: random stall per result, one long hold-off on request.
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 3) : 0;
			if (hold_off > 0) begin
				stall    = hold_off;
				hold_off = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			tracker.check_result(m_axis_tdata);
			@(negedge clk);
		end
	end

	// Give up when neither side has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", StallLimit);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int goal;
		tracker = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset thresholds (tap 15, swipe 30, keepalive 3 s).
		// NACK and empty reply with no touch: nothing, no keepalive
		send_poll(1'b0, 8'd0, 8'd0, 12'h000, 12'h000, 48'd100);
		send_poll(1'b1, 8'd0, 8'd0, 12'h000, 12'h000, 48'd200);
		// small wiggle, released by zero fingers: tap
		send_poll(1'b1, 8'd0, 8'd1, 12'h800, 12'h800, 48'd1000);
		send_poll(1'b1, 8'd0, 8'd1, 12'h805, 12'h7FB, 48'd2000);
		send_poll(1'b1, 8'd0, 8'd0, 12'h805, 12'h7FB, 48'd3000);
		// full-scale move to x = 0 (y still set), released by NACK: left
		send_poll(1'b1, 8'd0, 8'd255, 12'hFFF, 12'hFFF, 48'd4000);
		send_poll(1'b1, 8'd0, 8'd1, 12'h000, 12'hFFF, 48'd5000);
		send_poll(1'b0, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF);
		// touch with y = 0; controller gesture mid-touch passes through and
		// leaves tracking alone, idle just past the interval
		send_poll(1'b1, 8'd0, 8'd1, 12'h010, 12'h000, 48'd6000);
		send_poll(1'b1, HW_UP, 8'd1, 12'h123, 12'h456, 48'd3006001);
		// unknown code keeps tracking; zero coordinates end it: down
		send_poll(1'b1, 8'd6, 8'd1, 12'h010, 12'h100, 48'd7000);
		send_poll(1'b1, 8'd0, 8'd3, 12'h000, 12'h000, 48'd8000);
		// pass-through codes; idle exactly at, just over, and wrapped
		send_poll(1'b1, HW_DOWN, 8'd0, 12'h000, 12'h000, 48'd3007000);
		send_poll(1'b1, HW_LEFT, 8'd0, 12'h000, 12'h000, 48'd3007001);
		send_poll(1'b1, HW_RIGHT, 8'd0, 12'h000, 12'h000, 48'd5);
		send_poll(1'b1, HW_TAP, 8'd0, 12'h000, 12'h000, 48'd7500);
		// equal movement on both axes: nothing
		send_poll(1'b1, 8'd0, 8'd1, 12'd100, 12'd100, 48'd8000);
		send_poll(1'b1, 8'd0, 8'd1, 12'd140, 12'd140, 48'd8100);
		send_poll(1'b1, 8'd0, 8'd0, 12'd140, 12'd140, 48'd8200);
		// past tap but short of swipe: nothing
		send_poll(1'b1, 8'd0, 8'd1, 12'd200, 12'd200, 48'd9000);
		send_poll(1'b1, 8'd0, 8'd1, 12'd220, 12'd205, 48'd9100);
		send_poll(1'b0, 8'd0, 8'd0, 12'd0, 12'd0, 48'd9200);
		// upward swipe
		send_poll(1'b1, 8'd0, 8'd2, 12'd300, 12'd300, 48'd10000);
		send_poll(1'b1, 8'd0, 8'd2, 12'd300, 12'd200, 48'd10100);
		send_poll(1'b0, 8'd0, 8'd0, 12'd0, 12'd0, 48'd10200);
		clock_us = 48'd20000;

		// Random phases, each under its own register setting. Every third
		// phase runs without gaps and starts with a long result stall.
		for (int phase = 0; phase < 9; phase++) begin
			if (phase != 0) begin
				wait_idle();
				case (phase)
					1: program_regs(12'd0, 12'd0, 48'd0);
					2: program_regs(12'hFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF);
					3: program_regs(TapThreshRst, SwipeThreshRst, KeepaliveRst);
					4: program_regs(12'd0, 12'hFFF, 48'd1000);
					5: program_regs(12'hFFF, 12'd0, 48'd20000);
					6: program_regs(ThreshW'($urandom), ThreshW'($urandom),
						TimeW'($urandom_range(0, 100000)));
					7: program_regs(12'd60, 12'd25, 48'd50000);
					default: program_regs(12'd12, 12'd40, KeepaliveRst);
				endcase
			end
			idle_on = (phase % 3 != 2);
			if (!idle_on)
				hold_off = HoldOffCycles;
			goal = polls_sent + ItemsPerPhase;
			while (polls_sent < goal) begin
				case ($urandom_range(0, 9))
					7: send_poll(1'b1, pass_code(), 8'($urandom), CoordW'($urandom),
						CoordW'($urandom), next_stamp());
					8: send_poll(1'($urandom), 8'($urandom), 8'($urandom), CoordW'($urandom),
						CoordW'($urandom), next_stamp());
					9: send_poll(1'($urandom), ignored_code(), 8'd0, CoordW'($urandom),
						CoordW'($urandom), next_stamp());
					default: touch_stroke();
				endcase
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== touch_gesture_classifier_unit.f =====
rtl/tgc_pkg.sv
rtl/tgc_cfg.sv
rtl/tgc_classify.sv
rtl/touch_gesture_classifier_unit.sv
bench/tb_touch_gesture_classifier_unit.sv
